// ----- rtl/npv_pkg.sv -----
package npv_pkg;

  localparam int CashW        = 48;
  localparam int WordW        = 64;
  localparam int RateW        = 32;
  localparam int FactorFrac   = 40;
  localparam int RateFracBits = 30;
  localparam int RateShift    = FactorFrac - RateFracBits;
  // dividend is the cash magnitude followed by the factor's fraction bits
  localparam int DivBits      = CashW + FactorFrac;
  localparam int CntW         = $clog2(DivBits);
  localparam int MulSteps     = 4;
  localparam int AddrW        = 2;

  localparam logic [AddrW-1:0] ADDR_RATE = 2'd0;

  localparam logic [WordW-1:0] SAT_NEG = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_DIV  = 7'b000_0010,
    S_TERM = 7'b000_0100,
    S_SUM  = 7'b000_1000,
    S_MUL  = 7'b001_0000,
    S_FACT = 7'b010_0000,
    S_DONE = 7'b100_0000
  } state_e;

  typedef struct packed {
    logic       load_item;
    logic       div_step;
    logic       term_en;
    logic       sum_en;
    logic       mul_clr;
    logic       mul_issue;
    logic       mul_acc;
    logic [1:0] mul_idx;
    logic       fact_en;
    logic       out_load;
    logic       clear_series;
  } dp_cmd_t;

  typedef struct packed {
    logic rate_bad;
    logic last;
    logic out_blocked;
  } dp_status_t;

  // 1 + rate in Q24.40
  function automatic logic [WordW-1:0] one_plus_rate(input logic [RateW-1:0] rate);
    logic [WordW-1:0] rate_ext;
    rate_ext = {{(WordW - RateW){rate[RateW-1]}}, rate};
    return (WordW'(1) << FactorFrac) + (rate_ext << RateShift);
  endfunction

endpackage

// ----- rtl/npv_ctrl.sv -----
module npv_ctrl
  import npv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          cnt_d           = '0;
          // a rate of minus one skips the arithmetic and goes straight to finish
          state_d         = status_i.rate_bad ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivBits - 1)) begin
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        cmd_o.term_en = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        cnt_d        = '0;
        state_d      = S_MUL;
      end
      S_MUL: begin
        // issue one partial product per cycle, add it in the next
        cmd_o.mul_clr   = (cnt_q == '0);
        cmd_o.mul_issue = (cnt_q < CntW'(MulSteps));
        cmd_o.mul_acc   = (cnt_q != '0);
        cmd_o.mul_idx   = cnt_q[1:0];
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulSteps)) begin
          state_d = S_FACT;
        end
      end
      S_FACT: begin
        cmd_o.fact_en = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (!status_i.out_blocked) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.clear_series = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/npv_dpath.sv -----
module npv_dpath
  import npv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [RateW-1:0]        cfg_wdata_i,
  output logic [RateW-1:0]        rate_o,
  input  logic signed [CashW-1:0] cash_flow_i,
  input  logic                    last_period_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WordW-1:0] present_value_o,
  output logic                    overflow_flag_o,
  output logic                    rate_error_o
);

  logic [RateW-1:0]     rate_q;
  logic [WordW-1:0]     factor_q, factor_d;
  logic [WordW-1:0]     sum_q;
  logic                 sat_q;
  logic [DivBits-1:0]   nq_q;
  logic [WordW-1:0]     rem_q;
  logic                 term_neg_q;
  logic                 last_q;
  logic [WordW-1:0]     term_q;
  logic [WordW-1:0]     pp_q;
  logic [1:0]           pp_sh_q;
  logic [2*WordW-1:0]   acc_q;
  logic                 out_valid_q;
  logic [WordW-1:0]     out_pv_q;
  logic                 out_ovf_q;
  logic                 out_err_q;

  logic [WordW-1:0]     opr;
  logic [WordW-1:0]     opr_mag;
  logic [WordW-1:0]     fmag;
  logic [WordW-1:0]     divisor;
  logic [CashW-1:0]     cash_mag;
  logic [WordW:0]       rem_shift;
  logic [WordW:0]       rem_diff;
  logic                 rem_ge;
  logic                 term_over;
  logic [WordW-1:0]     term_low;
  logic [WordW-1:0]     term_d;
  logic                 term_sat;
  logic [WordW-1:0]     sum_add;
  logic                 sum_ovf;
  logic [WordW-1:0]     sum_d;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [2*WordW-1:0]   pp_shifted;
  logic                 fact_over;
  logic [WordW-1:0]     fact_res;
  logic                 fact_clamp;
  logic                 fact_neg;
  logic                 fact_sat;
  logic                 bad;

  assign opr      = one_plus_rate(rate_q);
  assign bad      = (opr == '0);
  assign opr_mag  = opr[WordW-1] ? (~opr + 1'b1) : opr;
  assign fmag     = factor_q[WordW-1] ? (~factor_q + 1'b1) : factor_q;
  assign divisor  = (fmag == '0) ? WordW'(1) : fmag;
  assign cash_mag = cash_flow_i[CashW-1] ? (~cash_flow_i + 1'b1) : cash_flow_i;

  // restoring divider, one quotient bit per step
  assign rem_shift = {rem_q, nq_q[DivBits-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign rem_ge    = ~rem_diff[WordW];

  // saturate the quotient to a signed term
  assign term_over = |nq_q[DivBits-1:WordW];
  assign term_low  = nq_q[WordW-1:0];
  always_comb begin
    term_d   = term_low;
    term_sat = 1'b0;
    if (term_neg_q) begin
      if (term_over || term_low > SAT_NEG) begin
        term_d   = SAT_NEG;
        term_sat = 1'b1;
      end else begin
        term_d = ~term_low + 1'b1;
      end
    end else if (term_over || term_low[WordW-1]) begin
      term_d   = SAT_POS;
      term_sat = 1'b1;
    end
  end

  assign sum_add = sum_q + term_q;
  assign sum_ovf = (sum_q[WordW-1] == term_q[WordW-1]) &&
                   (sum_add[WordW-1] != sum_q[WordW-1]);
  assign sum_d   = sum_ovf ? (sum_q[WordW-1] ? SAT_NEG : SAT_POS) : sum_add;

  // 64x64 product from four 32x32 partial products
  assign mul_a = cmd_i.mul_idx[0] ? fmag[63:32] : fmag[31:0];
  assign mul_b = cmd_i.mul_idx[1] ? opr_mag[63:32] : opr_mag[31:0];

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_shifted = {64'b0, pp_q};
      2'd1:    pp_shifted = {32'b0, pp_q, 32'b0};
      2'd2:    pp_shifted = {pp_q, 64'b0};
      default: pp_shifted = '0;
    endcase
  end

  // rescale the factor product and saturate
  assign fact_over  = |acc_q[2*WordW-1:WordW+FactorFrac];
  assign fact_clamp = ~fact_over && (acc_q[WordW+FactorFrac-1:FactorFrac] == '0) &&
                      (fmag != '0) && (opr_mag != '0);
  assign fact_res   = fact_clamp ? WordW'(1) : acc_q[WordW+FactorFrac-1:FactorFrac];
  assign fact_neg   = factor_q[WordW-1] ^ opr[WordW-1];
  always_comb begin
    factor_d = fact_res;
    fact_sat = fact_clamp;
    if (fact_neg) begin
      if (fact_over || fact_res > SAT_NEG) begin
        factor_d = SAT_NEG;
        fact_sat = 1'b1;
      end else begin
        factor_d = ~fact_res + 1'b1;
      end
    end else if (fact_over || fact_res[WordW-1]) begin
      factor_d = SAT_POS;
      fact_sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= '0;
      factor_q    <= one_plus_rate('0);
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q   <= cfg_wdata_i;
        factor_q <= one_plus_rate(cfg_wdata_i);
        sum_q    <= '0;
        sat_q    <= 1'b0;
      end else if (cmd_i.clear_series) begin
        factor_q <= opr;
        sum_q    <= '0;
        sat_q    <= 1'b0;
      end else begin
        if (cmd_i.sum_en) begin
          sum_q <= sum_d;
        end
        if (cmd_i.fact_en) begin
          factor_q <= factor_d;
        end
        if ((cmd_i.term_en && term_sat) || (cmd_i.sum_en && sum_ovf) ||
            (cmd_i.fact_en && fact_sat)) begin
          sat_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      nq_q       <= {cash_mag, {FactorFrac{1'b0}}};
      rem_q      <= '0;
      term_neg_q <= cash_flow_i[CashW-1] ^ factor_q[WordW-1];
      last_q     <= last_period_i;
    end else if (cmd_i.div_step) begin
      nq_q  <= {nq_q[DivBits-2:0], rem_ge};
      rem_q <= rem_ge ? rem_diff[WordW-1:0] : rem_shift[WordW-1:0];
    end
    if (cmd_i.term_en) begin
      term_q <= term_d;
    end
    if (cmd_i.mul_issue) begin
      pp_q    <= mul_a * mul_b;
      pp_sh_q <= {1'b0, cmd_i.mul_idx[0]} + {1'b0, cmd_i.mul_idx[1]};
    end
    if (cmd_i.mul_clr) begin
      acc_q <= '0;
    end else if (cmd_i.mul_acc) begin
      acc_q <= acc_q + pp_shifted;
    end
    if (cmd_i.out_load) begin
      out_pv_q  <= bad ? '0 : sum_q;
      out_ovf_q <= ~bad & sat_q;
      out_err_q <= bad;
    end
  end

  assign status_o.rate_bad    = bad;
  assign status_o.last        = last_q;
  assign status_o.out_blocked = out_valid_q & out_stall_i;

  assign rate_o          = rate_q;
  assign out_valid_o     = out_valid_q;
  assign present_value_o = signed'(out_pv_q);
  assign overflow_flag_o = out_ovf_q;
  assign rate_error_o    = out_err_q;

endmodule

// ----- rtl/net_present_value_accumulator.sv -----
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  cash_flow_i, last_period_i
// output    out        out_valid_o/out_stall_i present_value_o, overflow_flag_o, rate_error_o
// config    in         APB write, psel/penable discount_rate at byte address 0
//
// A new item is taken only after the previous one is finished: the accepting
// cycle, 88 steps of the radix-2 divider (48 magnitude bits plus 40 fraction
// bits), then term, sum, four 32x32 partial products, factor update and
// finish. With 1+rate zero an item goes straight from acceptance to finish. Reset
// sets the rate to zero, the factor to 1.0 and clears the sum. A last item holds
// in finish while the output register is full and stalled; non-last items never wait.
module net_present_value_accumulator
  import npv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CashW-1:0] cash_flow_i,
  input  logic                    last_period_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WordW-1:0] present_value_o,
  output logic                    overflow_flag_o,
  output logic                    rate_error_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [RateW-1:0]        pwdata,
  output logic [RateW-1:0]        prdata,
  output logic                    pready
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             cfg_we;
  logic [RateW-1:0] rate;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == ADDR_RATE);
  assign prdata = (paddr == ADDR_RATE) ? rate : '0;

  npv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  npv_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (pwdata),
    .rate_o          (rate),
    .cash_flow_i     (cash_flow_i),
    .last_period_i   (last_period_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .present_value_o (present_value_o),
    .overflow_flag_o (overflow_flag_o),
    .rate_error_o    (rate_error_o)
  );

endmodule
